FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is switched off while reset is asserted.
`define LG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked property that also holds across reset.
`define LG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lgpg_pkg.sv
package lgpg_pkg;

    // Coordinate width of the position input and the gradient end points.
    localparam int COORD_W  = 16;

    // Color channels and their layout.
    localparam int CH_N     = 4;
    localparam int COLOR_W  = 16;
    localparam int FRAC_SH  = 40;
    localparam int BYTE_LSB = 48;
    localparam int BYTE_TOP = 24;
    localparam int BYTE_W   = 8;

    // Only bits below the top of the channel byte matter in the accumulator.
    localparam int ACC_W    = BYTE_LSB + BYTE_W;
    localparam int SPLIT    = ACC_W / 2;
    localparam int PLO_W    = SPLIT + COORD_W;
    localparam int PHI_W    = ACC_W - SPLIT;

    // Long division of |delta| << 40 by the span.
    localparam int DIV_N_W  = COLOR_W + FRAC_SH;
    localparam int CNT_W    = $clog2(DIV_N_W);

    // Pixel packing.
    localparam int PIX_W    = 32;
    localparam int MASK_W   = 32;
    localparam int HB_W     = $clog2(PIX_W + 1);

    // Register file.
    localparam int REG_N     = 7;
    localparam int REG_IDX_W = $clog2(REG_N);
    localparam int ADDR_W    = REG_IDX_W + 3;
    localparam int DATA_W    = 64;

    localparam logic [REG_IDX_W-1:0] REG_START_COLORS    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_END_COLORS      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_MASK_RED_GREEN  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_MASK_BLUE_ALPHA = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_START_POSITION  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_END_POSITION    = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_ENABLE    = REG_IDX_W'(6);

    // Sequencer that recomputes the per-channel step after reset or a write.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } t_div_state;

    // One-based index of the highest set bit, zero for an empty mask.
    function automatic logic [HB_W-1:0] f_top_bit(input logic [MASK_W-1:0] w);
        logic [HB_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (w[i]) begin
                n = HB_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/linear_gradient_pixel_generator.sv
// Linear gradient pixel generator.
// Input channel: i_in_valid / o_in_ready carry one signed coordinate per beat
// on i_position. Output channel: o_out_valid / i_out_ready carry one packed
// 32-bit pixel per beat on o_pixel. Registers are written through the APB-style
// port at byte address 8*index, 64 bits each; the user must see that they are
// only changed while idle, which the block does not enforce. When the span
// end_position - start_position is not positive, accepted beats are consumed
// and produce no pixel. Throughput is one beat per cycle unless the receiver
// or the step sequencer holds input off; each pixel passes the clamp, multiply,
// accumulate and pack stages. The per-channel step is a long division done one
// quotient bit per cycle for all four channels at once: after reset and after
// every register write the input is held off for load, 56 division steps, finish.
// Reset clears all configuration registers to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops; no
// beat is lost or repeated.
`include "assert_macros.svh"

module linear_gradient_pixel_generator
    import lgpg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Coordinate channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_position,
    // Pixel channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PIX_W-1:0]          o_pixel,
    // Register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    // Configuration registers.
    logic [DATA_W-1:0]  r_start_colors;
    logic [DATA_W-1:0]  r_end_colors;
    logic [DATA_W-1:0]  r_mask_red_green;
    logic [DATA_W-1:0]  r_mask_blue_alpha;
    logic [COORD_W-1:0] r_start_position;
    logic [COORD_W-1:0] r_end_position;
    logic               r_alpha_enable;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Derived settings, latched by the step sequencer.
    logic [COORD_W-1:0] r_span;
    logic               r_span_pos;
    logic [ACC_W-1:0]   r_base  [CH_N];
    logic [MASK_W-1:0]  r_mask  [CH_N];
    logic [HB_W-1:0]    r_hb    [CH_N];
    logic [ACC_W-1:0]   r_step  [CH_N];

    // Divider lanes.
    t_div_state         r_state;
    t_div_state         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_quo   [CH_N];
    logic [COORD_W-1:0] r_rem   [CH_N];
    logic               r_neg   [CH_N];
    logic [DIV_N_W-1:0] n_quo   [CH_N];
    logic [COORD_W-1:0] n_rem   [CH_N];
    logic               do_load;
    logic               do_run;
    logic               do_finish;

    // Item pipeline.
    logic               en;
    logic               in_acc;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic [COORD_W-1:0] r_t;
    logic [PLO_W-1:0]   r_plo   [CH_N];
    logic [PHI_W-1:0]   r_phi   [CH_N];
    logic [BYTE_W-1:0]  r_byte  [CH_N];
    logic [PIX_W-1:0]   r_pixel;
    logic [COORD_W:0]   n_d;
    logic [COORD_W-1:0] n_t;
    logic [PIX_W-1:0]   n_pixel;

    // Register port: writes in the access phase, reads return the stored value.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_colors    <= '0;
            r_end_colors      <= '0;
            r_mask_red_green  <= '0;
            r_mask_blue_alpha <= '0;
            r_start_position  <= '0;
            r_end_position    <= '0;
            r_alpha_enable    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_START_COLORS:    r_start_colors    <= pwdata;
                REG_END_COLORS:      r_end_colors      <= pwdata;
                REG_MASK_RED_GREEN:  r_mask_red_green  <= pwdata;
                REG_MASK_BLUE_ALPHA: r_mask_blue_alpha <= pwdata;
                REG_START_POSITION:  r_start_position  <= pwdata[COORD_W-1:0];
                REG_END_POSITION:    r_end_position    <= pwdata[COORD_W-1:0];
                REG_ALPHA_ENABLE:    r_alpha_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_START_COLORS:    prdata = r_start_colors;
            REG_END_COLORS:      prdata = r_end_colors;
            REG_MASK_RED_GREEN:  prdata = r_mask_red_green;
            REG_MASK_BLUE_ALPHA: prdata = r_mask_blue_alpha;
            REG_START_POSITION:  prdata = DATA_W'(r_start_position);
            REG_END_POSITION:    prdata = DATA_W'(r_end_position);
            REG_ALPHA_ENABLE:    prdata = DATA_W'(r_alpha_enable);
            default:             prdata = '0;
        endcase
    end

    // Step sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (do_load) begin
                r_cnt <= CNT_W'(DIV_N_W - 1);
            end else if (do_run) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Next state: any register write restarts the step computation.
    always_comb begin
        n_state   = r_state;
        do_load   = 1'b0;
        do_run    = 1'b0;
        do_finish = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_LOAD: begin
                do_load = 1'b1;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                do_run = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                do_finish = 1'b1;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_LOAD;
        endcase
        if (cfg_wr) begin
            n_state = ST_LOAD;
        end
    end

    // One restoring division step per lane: shift in a dividend bit, subtract if it fits.
    always_comb begin
        logic [COORD_W:0] rem_sh;
        logic             fit;
        for (int c = 0; c < CH_N; c++) begin
            rem_sh   = {r_rem[c], r_quo[c][DIV_N_W-1]};
            fit      = rem_sh >= {1'b0, r_span};
            n_rem[c] = fit ? COORD_W'(rem_sh - {1'b0, r_span}) : rem_sh[COORD_W-1:0];
            n_quo[c] = {r_quo[c][DIV_N_W-2:0], fit};
        end
    end

    // Latch the derived settings, run the division, and fold in the floor rounding.
    always_ff @(posedge i_clk) begin
        logic [COLOR_W:0]   dlt;
        logic [COLOR_W-1:0] c0;
        logic [COLOR_W-1:0] c1;
        logic [COORD_W:0]   span_full;
        span_full = {r_end_position[COORD_W-1], r_end_position}
                  - {r_start_position[COORD_W-1], r_start_position};
        if (do_load) begin
            r_span     <= span_full[COORD_W-1:0];
            r_span_pos <= !span_full[COORD_W] && (span_full != '0);
            r_mask[0]  <= r_mask_red_green[MASK_W-1:0];
            r_mask[1]  <= r_mask_red_green[DATA_W-1:MASK_W];
            r_mask[2]  <= r_mask_blue_alpha[MASK_W-1:0];
            r_mask[3]  <= r_alpha_enable ? r_mask_blue_alpha[DATA_W-1:MASK_W] : '0;
            r_hb[0]    <= f_top_bit(r_mask_red_green[MASK_W-1:0]);
            r_hb[1]    <= f_top_bit(r_mask_red_green[DATA_W-1:MASK_W]);
            r_hb[2]    <= f_top_bit(r_mask_blue_alpha[MASK_W-1:0]);
            r_hb[3]    <= r_alpha_enable ? f_top_bit(r_mask_blue_alpha[DATA_W-1:MASK_W])
                                         : '0;
            for (int c = 0; c < CH_N; c++) begin
                c0        = r_start_colors[c*COLOR_W +: COLOR_W];
                c1        = r_end_colors[c*COLOR_W +: COLOR_W];
                dlt       = {1'b0, c1} - {1'b0, c0};
                r_neg[c]  <= dlt[COLOR_W];
                r_quo[c]  <= {(dlt[COLOR_W] ? COLOR_W'(~dlt + 1'b1) : dlt[COLOR_W-1:0]),
                              {FRAC_SH{1'b0}}};
                r_rem[c]  <= '0;
                r_base[c] <= {c0, {FRAC_SH{1'b0}}};
            end
        end else if (do_run) begin
            for (int c = 0; c < CH_N; c++) begin
                r_quo[c] <= n_quo[c];
                r_rem[c] <= n_rem[c];
            end
        end else if (do_finish) begin
            // Negative ramps round toward minus infinity: -q, or -q-1 = ~q with a remainder.
            for (int c = 0; c < CH_N; c++) begin
                if (!r_neg[c]) begin
                    r_step[c] <= r_quo[c];
                end else if (r_rem[c] != '0) begin
                    r_step[c] <= ~r_quo[c];
                end else begin
                    r_step[c] <= ACC_W'(~r_quo[c] + 1'b1);
                end
            end
        end
    end

    // Handshake: the pipeline moves as a whole whenever the last stage can drain.
    assign en          = !r_v4 || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && en;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_v4;
    assign o_pixel     = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= in_acc && r_span_pos;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1: offset from the start, clamped to the span.
    always_comb begin
        n_d = {i_position[COORD_W-1], i_position}
            - {r_start_position[COORD_W-1], r_start_position};
        if (n_d[COORD_W]) begin
            n_t = '0;
        end else if (n_d[COORD_W-1:0] > r_span) begin
            n_t = r_span;
        end else begin
            n_t = n_d[COORD_W-1:0];
        end
    end

    // Stage 4 combinational part: place each byte under its mask.
    always_comb begin
        logic [PIX_W-1:0] word;
        logic [HB_W-1:0]  sh;
        n_pixel = '0;
        for (int c = 0; c < CH_N; c++) begin
            word    = {r_byte[c], {BYTE_TOP{1'b0}}};
            sh      = HB_W'(PIX_W) - r_hb[c];
            n_pixel = n_pixel | ((word >> sh) & r_mask[c]);
        end
    end

    // Payload stages: clamp, split multiply, accumulate, pack.
    always_ff @(posedge i_clk) begin
        logic [ACC_W-1:0] acc;
        if (en) begin
            r_t <= n_t;
            for (int c = 0; c < CH_N; c++) begin
                r_plo[c]  <= PLO_W'(r_step[c][SPLIT-1:0]) * PLO_W'(r_t);
                r_phi[c]  <= PHI_W'(r_step[c][ACC_W-1:SPLIT] * r_t);
                acc       = r_base[c] + ACC_W'(r_plo[c]) + {r_phi[c], {SPLIT{1'b0}}};
                r_byte[c] <= acc[ACC_W-1:BYTE_LSB];
            end
            r_pixel <= n_pixel;
        end
    end

    // Checks on the sequencer and the pipeline.
    `LG_ASSERT_ALWAYS(a_reset_restarts, i_clk,
        !i_rst_n |=> (r_state == ST_LOAD) && !o_out_valid,
        "reset did not restart the step computation")
    `LG_ASSERT(a_write_restarts, i_clk, i_rst_n,
        (psel && penable && pwrite) |=> (r_state == ST_LOAD) && !o_in_ready,
        "register write did not hold off input for the step computation")
    `LG_ASSERT(a_accept_enters, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && r_span_pos) |=> r_v1,
        "accepted coordinate with a positive span did not enter the pipeline")
    `LG_ASSERT(a_clamped, i_clk, i_rst_n,
        r_v1 |-> (r_t <= r_span),
        "clamped offset exceeds the span")
    `LG_ASSERT(a_rem_below_span, i_clk, i_rst_n,
        ((r_state == ST_FINISH) && r_span_pos) |-> (r_rem[0] < r_span),
        "division remainder not below the span")

endmodule
